### hdl/tga_pkg.sv
// ============================================================================
// tga_pkg
// Shared types, constants and register indexes for the TGA RLE pixel decoder.
// ============================================================================
package tga_pkg;

    localparam int COORD_BITS  = 16;   // default coordinate width
    localparam int MAX_RUN     = 128;  // longest packet
    localparam int QUEUE_DEPTH = 4;    // front-to-back command queue

    localparam int CFG_W     = 16;     // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 16;     // x_start / dest_row field width
    localparam int COUNT_W   = 8;      // run length field width

    localparam logic [CFG_IDX_W-1:0] NUM_REGS = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_FOUR_BYTE_PIXELS = 3'd2,
        REG_RLE_ENABLE       = 3'd3,
        REG_FLIP_ROWS        = 3'd4
    } reg_index_t;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 16'd64;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 16'd64;
    localparam logic             RST_FOUR_BYTE    = 1'b1;
    localparam logic             RST_RLE_ENABLE   = 1'b0;
    localparam logic             RST_FLIP_ROWS    = 1'b1;

    localparam int         HDR_REPEAT_BIT = 7;      // header bit 7: repeat packet
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;  // alpha for 24-bit pixels
    localparam logic [1:0] LAST_IDX_32    = 2'd3;   // byte index of final byte
    localparam logic [1:0] LAST_IDX_24    = 2'd2;
    localparam logic [CFG_W-1:0] MIN_WIDTH = 16'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
    } in_t;

    typedef struct packed {
        logic [7:0]         chan0;
        logic [7:0]         chan1;
        logic [7:0]         chan2;
        logic [7:0]         chan3;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] dest_row;
        logic [COUNT_W-1:0] seg_count;
        logic               last_of_item;
        logic               image_done;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic             four_byte_pixels;
        logic             rle_enable;
        logic             flip_rows;
    } cfg_t;

    // one decoded colour and how many pixels it covers
    typedef struct packed {
        logic [7:0]         chan0;
        logic [7:0]         chan1;
        logic [7:0]         chan2;
        logic [7:0]         chan3;
        logic [COUNT_W-1:0] count;
        logic               final_run;  // ends the image
        logic               restart;    // reset column/row before this run
    } cmd_t;

endpackage

### hdl/tga_cfg.sv
// ============================================================================
// tga_cfg
// Configuration registers, pixel total of the image and restart pulse.
// ============================================================================
module tga_cfg #(
    parameter int COORD_BITS = tga_pkg::COORD_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tga_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tga_pkg::CFG_W-1:0]       cfg_wdata,
    output tga_pkg::cfg_t                   cfg,
    output logic [2*COORD_BITS-1:0]         total,
    output logic                            restart
);

    localparam int PL_W = 2 * COORD_BITS;

    tga_pkg::cfg_t          cfg_reg, cfg_next;
    logic                   hold_reg, hold_next;
    logic [PL_W-1:0]        total_reg, total_next;
    logic [COORD_BITS-1:0]  geo_w, geo_h;

    always_comb begin
        cfg_next  = cfg_reg;
        hold_next = 1'b0;
        if (cfg_we) begin
            unique case (tga_pkg::reg_index_t'(cfg_index))
                tga_pkg::REG_IMAGE_WIDTH: begin
                    cfg_next.image_width = cfg_wdata;
                    hold_next = 1'b1;
                end
                tga_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_next.image_height = cfg_wdata;
                    hold_next = 1'b1;
                end
                tga_pkg::REG_FOUR_BYTE_PIXELS: begin
                    cfg_next.four_byte_pixels = cfg_wdata[0];
                    hold_next = 1'b1;
                end
                tga_pkg::REG_RLE_ENABLE: begin
                    cfg_next.rle_enable = cfg_wdata[0];
                    hold_next = 1'b1;
                end
                tga_pkg::REG_FLIP_ROWS: begin
                    cfg_next.flip_rows = cfg_wdata[0];
                    hold_next = 1'b1;
                end
                default: begin
                    hold_next = 1'b0;
                end
            endcase
        end
    end

    assign geo_w = cfg_reg.image_width[COORD_BITS-1:0];
    assign geo_h = cfg_reg.image_height[COORD_BITS-1:0];

    // empty image when narrower than three pixels or no rows
    always_comb begin
        if ((tga_pkg::CFG_W'(geo_w) < tga_pkg::MIN_WIDTH) || (geo_h == '0)) begin
            total_next = '0;
        end else begin
            total_next = PL_W'(geo_w) * PL_W'(geo_h);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width      <= tga_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height     <= tga_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.four_byte_pixels <= tga_pkg::RST_FOUR_BYTE;
            cfg_reg.rle_enable       <= tga_pkg::RST_RLE_ENABLE;
            cfg_reg.flip_rows        <= tga_pkg::RST_FLIP_ROWS;
            hold_reg                 <= 1'b1;
        end else begin
            cfg_reg  <= cfg_next;
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
    end

    assign cfg     = cfg_reg;
    assign total   = total_reg;
    assign restart = hold_reg;

endmodule

### hdl/tga_front.sv
// ============================================================================
// tga_front
// Byte parser: packet headers, pixel assembly, clipping at the image end.
// ============================================================================
module tga_front #(
    parameter int COORD_BITS = tga_pkg::COORD_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tga_pkg::cfg_t            cfg,
    input  logic [2*COORD_BITS-1:0]  total,
    input  logic                     cfg_restart,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tga_pkg::in_t             s_data,
    input  logic                     q_full,
    output logic                     push,
    output tga_pkg::cmd_t            push_data
);

    localparam int PL_W = 2 * COORD_BITS;
    localparam int CW   = tga_pkg::COUNT_W;

    logic            expect_reg, expect_next;
    logic [1:0]      idx_reg, idx_next;
    logic [23:0]     colour_reg, colour_next;
    logic [CW-1:0]   pleft_reg, pleft_next;
    logic            repeat_reg, repeat_next;
    logic [PL_W-1:0] pl_reg, pl_next;
    logic            fresh_reg, fresh_next;
    logic            pend_reg, pend_next;

    logic            accept, start;
    logic [7:0]      b;
    logic            base_expect, base_repeat;
    logic [1:0]      base_idx, last_idx;
    logic [CW-1:0]   base_pleft, pk, n;
    logic [PL_W-1:0] base_pl;

    assign s_ready = !cfg_restart && !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign start   = s_data.start_of_image;
    assign last_idx = cfg.four_byte_pixels ? tga_pkg::LAST_IDX_32 : tga_pkg::LAST_IDX_24;

    always_comb begin
        base_expect = start ? cfg.rle_enable : expect_reg;
        base_idx    = start ? 2'd0 : idx_reg;
        base_pleft  = start ? '0 : pleft_reg;
        base_repeat = start ? 1'b0 : repeat_reg;
        base_pl     = (start || fresh_reg) ? total : pl_reg;

        expect_next = expect_reg;
        idx_next    = idx_reg;
        colour_next = colour_reg;
        pleft_next  = pleft_reg;
        repeat_next = repeat_reg;
        pl_next     = pl_reg;
        fresh_next  = fresh_reg;
        pend_next   = pend_reg;
        push        = 1'b0;
        pk          = '0;
        n           = '0;

        push_data.chan0     = colour_reg[7:0];
        push_data.chan1     = colour_reg[15:8];
        push_data.chan2     = cfg.four_byte_pixels ? colour_reg[23:16] : b;
        push_data.chan3     = cfg.four_byte_pixels ? b : tga_pkg::ALPHA_OPAQUE;
        push_data.count     = '0;
        push_data.final_run = 1'b0;
        push_data.restart   = start || pend_reg;

        if (cfg_restart) begin
            expect_next = cfg.rle_enable;
            idx_next    = 2'd0;
            pleft_next  = '0;
            repeat_next = 1'b0;
            fresh_next  = 1'b1;
            pend_next   = 1'b0;
        end else if (accept) begin
            expect_next = base_expect;
            idx_next    = base_idx;
            pleft_next  = base_pleft;
            repeat_next = base_repeat;
            pl_next     = base_pl;
            fresh_next  = 1'b0;
            pend_next   = pend_reg || start;

            if (base_pl == '0) begin
                // image complete: byte dropped
            end else if (cfg.rle_enable && base_expect) begin
                repeat_next = b[tga_pkg::HDR_REPEAT_BIT];
                pleft_next  = CW'(b[6:0]) + CW'(1);
                expect_next = 1'b0;
                idx_next    = 2'd0;
            end else if (base_idx < last_idx) begin
                case (base_idx)
                    2'd0:    colour_next[7:0]   = b;
                    2'd1:    colour_next[15:8]  = b;
                    2'd2:    colour_next[23:16] = b;
                    default: colour_next        = colour_reg;
                endcase
                idx_next = base_idx + 2'd1;
            end else begin
                idx_next = 2'd0;
                if (cfg.rle_enable) begin
                    pk = (base_pleft == '0) ? CW'(1) : base_pleft;
                    if (base_repeat) begin
                        n          = pk;
                        pleft_next = '0;
                    end else begin
                        n          = CW'(1);
                        pleft_next = pk - CW'(1);
                    end
                    expect_next = (pleft_next == '0);
                end else begin
                    n = CW'(1);
                end
                if (PL_W'(n) > base_pl) begin
                    n = base_pl[CW-1:0];
                end
                pl_next             = base_pl - PL_W'(n);
                push                = 1'b1;
                push_data.count     = n;
                push_data.final_run = (pl_next == '0);
                pend_next           = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg <= tga_pkg::RST_RLE_ENABLE;
            idx_reg    <= 2'd0;
            pleft_reg  <= '0;
            repeat_reg <= 1'b0;
            fresh_reg  <= 1'b1;
            pend_reg   <= 1'b0;
        end else begin
            expect_reg <= expect_next;
            idx_reg    <= idx_next;
            pleft_reg  <= pleft_next;
            repeat_reg <= repeat_next;
            fresh_reg  <= fresh_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        colour_reg <= colour_next;
        pl_reg     <= pl_next;
    end

endmodule

### hdl/tga_queue.sv
// ============================================================================
// tga_queue
// Small FIFO of decoded runs between parser and segment generator.
// ============================================================================
module tga_queue #(
    parameter int DEPTH = tga_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tga_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output tga_pkg::cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    tga_pkg::cmd_t    store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/tga_back.sv
// ============================================================================
// tga_back
// Splits each run into row segments and drives the registered result beat.
// ============================================================================
module tga_back #(
    parameter int COORD_BITS = tga_pkg::COORD_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tga_pkg::cfg_t cfg,
    input  logic          cfg_restart,
    input  logic          q_valid,
    input  tga_pkg::cmd_t q_data,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output tga_pkg::out_t m_data
);

    localparam int CB = COORD_BITS;
    localparam int CW = tga_pkg::COUNT_W;

    tga_pkg::cmd_t  cur_reg, cur_next;
    logic           cv_reg, cv_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [CB-1:0]  col_reg, col_next;
    logic [CB-1:0]  row_reg, row_next;
    logic           mv_reg, mv_next;
    tga_pkg::out_t  md_reg, md_next;

    logic [CB-1:0]  w, h, room, drow;
    logic [CW-1:0]  seg, rem_after;
    logic [CB:0]    col_sum;
    logic           emit, seg_last, wrap;

    assign w = cfg.image_width[CB-1:0];
    assign h = cfg.image_height[CB-1:0];

    assign emit = cv_reg && (!mv_reg || m_ready);

    always_comb begin
        room      = (col_reg < w) ? (w - col_reg) : CB'(1);
        seg       = (CB'(rem_reg) < room) ? rem_reg : room[CW-1:0];
        rem_after = rem_reg - seg;
        seg_last  = (rem_after == '0);
        col_sum   = {1'b0, col_reg} + (CB+1)'(seg);
        wrap      = (col_sum >= {1'b0, w});
        drow      = cfg.flip_rows ? (h - CB'(1) - row_reg) : row_reg;
    end

    assign pop = q_valid && (!cv_reg || (emit && seg_last));

    always_comb begin
        cur_next = cur_reg;
        cv_next  = cv_reg;
        rem_next = rem_reg;
        col_next = col_reg;
        row_next = row_reg;
        mv_next  = mv_reg;
        md_next  = md_reg;

        if (emit) begin
            md_next.chan0        = cur_reg.chan0;
            md_next.chan1        = cur_reg.chan1;
            md_next.chan2        = cur_reg.chan2;
            md_next.chan3        = cur_reg.chan3;
            md_next.x_start      = tga_pkg::COORD_W'(col_reg);
            md_next.dest_row     = tga_pkg::COORD_W'(drow);
            md_next.seg_count    = seg;
            md_next.last_of_item = seg_last;
            md_next.image_done   = cur_reg.final_run && seg_last;
            mv_next              = 1'b1;
            rem_next             = rem_after;
            if (wrap) begin
                col_next = '0;
                row_next = row_reg + CB'(1);
            end else begin
                col_next = col_sum[CB-1:0];
            end
            if (seg_last) begin
                cv_next = 1'b0;
            end
        end else if (m_ready) begin
            mv_next = 1'b0;
        end

        // a restart flag takes effect after the previous run's last segment
        if (pop) begin
            cur_next = q_data;
            rem_next = q_data.count;
            cv_next  = 1'b1;
            if (q_data.restart) begin
                col_next = '0;
                row_next = '0;
            end
        end

        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg  <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            cv_reg  <= cv_next;
            col_reg <= col_next;
            row_reg <= row_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        md_reg  <= md_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule

### hdl/tga_rle_pixel_decoder_core.sv
// ============================================================================
// tga_rle_pixel_decoder_core
// TGA truecolor pixel-data decoder (raw or run-length) emitting row segments.
// ============================================================================
// Input channel s_*: one pixel-data byte per beat; start_of_image restarts the
// image with that byte. Output channel m_*: one row segment per beat (colour,
// column, destination row, length, last-of-run and image-done flags).
// A parser accepts one byte per cycle while the queue has room and turns each
// completed pixel into a run; a 4-entry run queue feeds the segment generator,
// which issues one segment per cycle into the output register while m_* is
// not stalled. A run that spans k rows becomes k segments in the generator.
// The first segment of a byte passes the run queue, the current-run register
// and the output register. Header and leading colour bytes produce no beat.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle; a
// write to a defined index restarts decoding, and s_ready is low for the
// following cycle while the pixel total (width times height) is recomputed.
// Reset: synchronous, active low; registers take their defaults and s_ready
// stays low for one cycle after reset. When m_ready is low, the result beat
// holds, the generator waits, and s_ready drops once the queue is full.
// ============================================================================
module tga_rle_pixel_decoder_core #(
    parameter int COORD_BITS  = tga_pkg::COORD_BITS,
    parameter int QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tga_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tga_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tga_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tga_pkg::out_t                 m_data
);

    tga_pkg::cfg_t           cfg;
    logic [2*COORD_BITS-1:0] total;
    logic                    cfg_restart;
    logic                    q_full, push, pop, q_valid;
    tga_pkg::cmd_t           push_data, q_data;

    tga_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .total     (total),
        .restart   (cfg_restart)
    );

    tga_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .total       (total),
        .cfg_restart (cfg_restart),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    tga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .rd_valid  (q_valid),
        .rd_data   (q_data)
    );

    tga_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cfg_restart (cfg_restart),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### hdl/tga_checker.sv
// ============================================================================
// tga_checker
// Port-level checks for the TGA RLE pixel decoder, bound to the top level.
// ============================================================================
module tga_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_we,
    input logic [tga_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input tga_pkg::out_t                 m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_seg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.seg_count != '0))
        else $error("empty segment");

    // a segment never runs past the end of the coordinate range
    a_seg_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.x_start} + 17'(m_data.seg_count)
                     <= 17'(tga_pkg::COORD_W'(16'hFFFF)) + 17'd1))
        else $error("segment exceeds coordinate range");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_done |-> m_data.last_of_item)
        else $error("image_done without last_of_item");

    // a write to a defined register blocks input for the next cycle
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index < tga_pkg::NUM_REGS) |=> !s_ready)
        else $error("input accepted right after register write");

endmodule

bind tga_rle_pixel_decoder_core tga_checker u_checker (.*);

### verif/tga_rle_pixel_decoder_core_tb.sv
// ============================================================================
// tga_rle_pixel_decoder_core_tb
// Self-checking bench for the TGA raw/RLE pixel decoder core.
//
// Bytes go in as beats on s_*. A scoreboard decodes each accepted beat
// into the row segments the core should emit. Every segment on m_* is
// checked against the oldest predicted one.
// The run starts with a short directed set: defaults, clipping, restart,
// the largest geometry and empty images. Random settings follow, fed
// with mostly well-formed images. Stray bytes and images cut short are
// mixed in. Both sides stall at random.
// ============================================================================
module tga_rle_pixel_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 330;
    localparam int unsigned PHASE_QUOTA  = 55;
    localparam int unsigned DRAIN_GAP    = 12;    // cycles of slack after the last segment
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on any port
    localparam int unsigned END_LIMIT    = 5000;

    // ------------------------------------------------------------------------
    // Decoder state mirror and segment checker
    // ------------------------------------------------------------------------
    class segment_scoreboard;
        tga_pkg::cfg_t regs;
        bit            want_header;
        logic [1:0]    byte_pos;
        logic [23:0]   held_bytes;
        logic [7:0]    run_left;
        bit            run_is_repeat;
        logic [15:0]   col;
        logic [15:0]   row;
        logic [31:0]   pix_left;
        tga_pkg::out_t segs_due[$];
        int unsigned   n_errors;
        int unsigned   n_checked;
        int unsigned   n_images;

        function void restart_image();
            logic [31:0] w32;
            logic [31:0] h32;
            w32 = {16'd0, regs.image_width};
            h32 = {16'd0, regs.image_height};
            want_header   = regs.rle_enable;
            byte_pos      = '0;
            held_bytes    = '0;
            run_left      = '0;
            run_is_repeat = 1'b0;
            col           = '0;
            row           = '0;
            pix_left = (regs.image_width < tga_pkg::MIN_WIDTH ||
                        regs.image_height == '0) ? 32'd0 : w32 * h32;
        endfunction

        function void reset_all();
            regs.image_width      = tga_pkg::RST_IMAGE_WIDTH;
            regs.image_height     = tga_pkg::RST_IMAGE_HEIGHT;
            regs.four_byte_pixels = tga_pkg::RST_FOUR_BYTE;
            regs.rle_enable       = tga_pkg::RST_RLE_ENABLE;
            regs.flip_rows        = tga_pkg::RST_FLIP_ROWS;
            restart_image();
        endfunction

        function void write_reg(tga_pkg::reg_index_t idx,
                                logic [tga_pkg::CFG_W-1:0] val);
            case (idx)
                tga_pkg::REG_IMAGE_WIDTH:      regs.image_width      = val;
                tga_pkg::REG_IMAGE_HEIGHT:     regs.image_height     = val;
                tga_pkg::REG_FOUR_BYTE_PIXELS: regs.four_byte_pixels = val[0];
                tga_pkg::REG_RLE_ENABLE:       regs.rle_enable       = val[0];
                tga_pkg::REG_FLIP_ROWS:        regs.flip_rows        = val[0];
                default: return;
            endcase
            restart_image();
        endfunction

        // Returns 1 when the byte was consumed, 0 when the image is over.
        function bit decode_byte(tga_pkg::in_t beat);
            logic [1:0]    top_idx;
            logic [7:0]    b;
            logic [7:0]    c2;
            logic [7:0]    c3;
            logic [31:0]   n;
            logic [31:0]   seg;
            logic [31:0]   room;
            logic [15:0]   w;
            tga_pkg::out_t s;
            b = beat.data_byte;
            top_idx = regs.four_byte_pixels ? tga_pkg::LAST_IDX_32 : tga_pkg::LAST_IDX_24;
            if (beat.start_of_image) begin
                restart_image();
            end
            if (pix_left == 0) begin
                return 1'b0;
            end
            if (regs.rle_enable && want_header) begin
                run_is_repeat = b[tga_pkg::HDR_REPEAT_BIT];
                run_left      = {1'b0, b[6:0]} + 8'd1;
                want_header   = 1'b0;
                byte_pos      = '0;
                return 1'b1;
            end
            if (byte_pos < top_idx) begin
                held_bytes[8*byte_pos +: 8] = b;
                byte_pos = byte_pos + 2'd1;
                return 1'b1;
            end
            byte_pos = '0;
            c2 = regs.four_byte_pixels ? held_bytes[23:16] : b;
            c3 = regs.four_byte_pixels ? b : tga_pkg::ALPHA_OPAQUE;

            n = 32'd1;
            if (regs.rle_enable) begin
                if (run_left == 0) begin
                    run_left = 8'd1;
                end
                if (run_is_repeat) begin
                    n = {24'd0, run_left};
                    run_left = '0;
                end else begin
                    run_left = run_left - 8'd1;
                end
                if (run_left == 0) begin
                    want_header = 1'b1;
                end
            end
            if (n > pix_left) begin
                n = pix_left;
            end

            // split the run at row ends
            w = regs.image_width;
            while (n > 0) begin
                room = (col < w) ? {16'd0, w - col} : 32'd1;
                seg  = (n < room) ? n : room;
                n        = n - seg;
                pix_left = pix_left - seg;
                s.chan0        = held_bytes[7:0];
                s.chan1        = held_bytes[15:8];
                s.chan2        = c2;
                s.chan3        = c3;
                s.x_start      = col;
                s.dest_row     = regs.flip_rows ? regs.image_height - 16'd1 - row : row;
                s.seg_count    = seg[7:0];
                s.last_of_item = (n == 0);
                s.image_done   = (pix_left == 0);
                segs_due.push_back(s);
                col = col + seg[15:0];
                if (col >= w) begin
                    col = '0;
                    row = row + 16'd1;
                end
            end
            return 1'b1;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_segment(tga_pkg::out_t got);
            tga_pkg::out_t want;
            if (segs_due.size() == 0) begin
                $error("segment with none expected: x %0d row %0d count %0d",
                       got.x_start, got.dest_row, got.seg_count);
                n_errors++;
                return;
            end
            want = segs_due.pop_front();
            n_checked++;
            if (want.image_done) begin
                n_images++;
            end
            cmp_field("chan0", 32'(want.chan0), 32'(got.chan0));
            cmp_field("chan1", 32'(want.chan1), 32'(got.chan1));
            cmp_field("chan2", 32'(want.chan2), 32'(got.chan2));
            cmp_field("chan3", 32'(want.chan3), 32'(got.chan3));
            cmp_field("x_start", 32'(want.x_start), 32'(got.x_start));
            cmp_field("dest_row", 32'(want.dest_row), 32'(got.dest_row));
            cmp_field("seg_count", 32'(want.seg_count), 32'(got.seg_count));
            cmp_field("last_of_item", 32'(want.last_of_item), 32'(got.last_of_item));
            cmp_field("image_done", 32'(want.image_done), 32'(got.image_done));
        endfunction

        function int unsigned pending();
            return segs_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus
    // ------------------------------------------------------------------------
    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [tga_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tga_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    tga_pkg::in_t                  s_data;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    tga_pkg::out_t                 m_data;

    segment_scoreboard sb;
    bit                no_gaps = 1'b0;
    int unsigned       useful_bytes = 0;
    int unsigned       n_settings = 0;
    int unsigned       quiet_cycles = 0;

    tga_rle_pixel_decoder_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(negedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_segment(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $error("no beat for %0d cycles, %0d segments outstanding",
                   STALL_LIMIT, sb.pending());
            $display("tga_rle_pixel_decoder_core test failed");
            $finish;
        end
    end

    // All driving tasks start and end at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        tga_pkg::in_t beat;
        beat.data_byte      = b;
        beat.start_of_image = sof;
        while (!no_gaps && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (sb.decode_byte(beat)) begin
            useful_bytes++;
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        // header and partial-pixel bytes may still be in the parser
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    task automatic set_reg(input tga_pkg::reg_index_t idx,
                           input logic [tga_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [tga_pkg::CFG_W-1:0] w,
                             input logic [tga_pkg::CFG_W-1:0] h,
                             input bit four, input bit rle, input bit flip);
        drain_results();
        set_reg(tga_pkg::REG_IMAGE_WIDTH, w);
        set_reg(tga_pkg::REG_IMAGE_HEIGHT, h);
        set_reg(tga_pkg::REG_FOUR_BYTE_PIXELS, {15'd0, four});
        set_reg(tga_pkg::REG_RLE_ENABLE, {15'd0, rle});
        set_reg(tga_pkg::REG_FLIP_ROWS, {15'd0, flip});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_pixel(input bit sof);
        int unsigned k;
        int unsigned n_bytes;
        n_bytes = sb.regs.four_byte_pixels ? 4 : 3;
        for (k = 0; k < n_bytes; k++) begin
            send_byte(8'($urandom_range(255)), sof && (k == 0));
        end
    endtask

    function automatic int unsigned run_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) begin
            return $urandom_range(6, 1);
        end else if (r < 90) begin
            return $urandom_range(127, 7);
        end
        return 128;
    endfunction

    // Mostly whole images, with stray bytes and images cut off midway.
    task automatic random_images(input int unsigned quota);
        longint unsigned to_go;
        int unsigned     stop_at;
        int unsigned     cnt;
        int unsigned     k;
        int unsigned     r;
        logic [7:0]      hdr;
        bit              first;
        bit              rep;
        stop_at = useful_bytes + quota;
        while (useful_bytes < stop_at) begin
            to_go = 64'(sb.regs.image_width);
            to_go = to_go * 64'(sb.regs.image_height);
            first = 1'b1;
            while (to_go > 0 && useful_bytes < stop_at) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end else if (r < 6 && !first) begin
                    repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
                    break;
                end
                cnt = run_length();
                if (sb.regs.rle_enable) begin
                    rep = 1'($urandom_range(1));
                    if (!rep && cnt > 12) begin
                        cnt = $urandom_range(12, 1);
                    end
                    hdr = 8'(cnt - 1);
                    hdr[tga_pkg::HDR_REPEAT_BIT] = rep;
                    send_byte(hdr, first);
                    if (rep) begin
                        send_pixel(1'b0);
                    end else begin
                        for (k = 0; k < cnt; k++) begin
                            send_pixel(1'b0);
                        end
                    end
                end else begin
                    if (cnt > 4) begin
                        cnt = $urandom_range(4, 1);
                    end
                    for (k = 0; k < cnt; k++) begin
                        send_pixel(first && (k == 0));
                    end
                end
                first = 1'b0;
                to_go = (64'(cnt) < to_go) ? to_go - 64'(cnt) : 64'd0;
                if (r >= 6 && r < 9) begin
                    drain_results();
                end
            end
            // trailing bytes past the end of a finished image are dropped
            repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial begin
        int unsigned               phase;
        int unsigned               base;
        int unsigned               guard;
        logic [tga_pkg::CFG_W-1:0] w;
        logic [tga_pkg::CFG_W-1:0] h;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = tga_pkg::REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        sb = new();
        sb.reset_all();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: one RGBA pixel lands on the bottom row, then a partial
        // pixel that the register writes below throw away
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);

        // 3x2 RGB: longest repeat split over both rows and clipped,
        // a byte past the end, then a restart with a raw packet
        configure(16'd3, 16'd2, 1'b0, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b0);

        // largest geometry, flipped
        configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);

        // empty images: too narrow, then zero rows
        configure(16'd2, 16'd5, 1'b1, 1'b0, 1'b1);
        send_byte(8'h12, 1'b1);
        configure(16'd3, 16'd0, 1'b1, 1'b0, 1'b1);
        send_byte(8'h34, 1'b1);

        base = useful_bytes;
        phase = 0;
        while (useful_bytes - base < RANDOM_ITEMS) begin
            w = ($urandom_range(99) < 75) ? tga_pkg::CFG_W'($urandom_range(8, 3))
                                          : tga_pkg::CFG_W'($urandom_range(40, 9));
            h = tga_pkg::CFG_W'($urandom_range(5, 1));
            if (phase == 1) begin
                w = 16'd3;
                h = 16'd1;
            end else if (phase == 4) begin
                w = 16'hFFFF;
                h = ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
            end
            case (phase)
                0:       configure(w, h, 1'b0, 1'b1, 1'b1);
                1:       configure(w, h, 1'b1, 1'b0, 1'b0);
                default: configure(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)));
            endcase
            no_gaps = (phase == 2);
            random_images(PHASE_QUOTA);
            no_gaps = 1'b0;
            phase++;
        end

        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < END_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (DRAIN_GAP) @(negedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected segments never arrived", sb.pending());
            sb.n_errors += sb.pending();
        end

        $display("Decoded %0d bytes over %0d register settings plus the reset defaults.",
                 useful_bytes, n_settings);
        $display("Checked %0d row segments, %0d of them closing an image.",
                 sb.n_checked, sb.n_images);
        if (sb.n_errors == 0) begin
            $display("tga_rle_pixel_decoder_core test passed");
        end else begin
            $display("tga_rle_pixel_decoder_core test failed");
        end
        $finish;
    end

endmodule
